[hw/rtl/positional_array_list_engine_core_assert.svh]
// assertion macros for the array list engine core
// used by the top level only, no other dependencies
`ifndef POSITIONAL_ARRAY_LIST_ENGINE_CORE_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ENGINE_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PALE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define PALE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[hw/rtl/pale_pkg.sv]
// shared types and constants for the array list engine
// no dependencies
`default_nettype none
package pale_pkg;
    localparam int DEPTH = 64;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [1:0] OP_INS = 2'd0;
    localparam logic [1:0] OP_DEL = 2'd1;
    localparam logic [1:0] OP_SRCH = 2'd2;
    localparam logic [1:0] OP_DEDUP = 2'd3;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_MISS = 2'd3;
    // command broadcast to all cells
    typedef struct packed {
        logic              ins;     // shift up from pos
        logic              del;     // shift down from pos
        logic              cmp;     // compare against key
        logic              kill;    // mark matches of key after pos dead
        logic              pack;    // compact step
        logic [CW-1:0]     pos;     // 0-based boundary
        logic [31:0]       key;
    } pale_cmd_t;
endpackage
`default_nettype wire

[hw/rtl/pale_cell.sv]
// one list slot: value register with shift, compare and compaction
// depends on pale_pkg
`default_nettype none
module pale_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [pale_pkg::CW-1:0] idx,
    input  wire pale_pkg::pale_cmd_t cmd,
    input  wire logic [pale_pkg::CW-1:0] cnt,
    input  wire logic [31:0]       left_val,
    input  wire logic [31:0]       right_val,
    input  wire logic              right_live,
    input  wire logic              left_hole,
    output logic [31:0]            val,
    output logic                   live,
    output logic                   hit,
    output logic                   hole
);
    logic [31:0] val_reg;
    logic        live_reg;
    logic        used;

    assign used = idx < cnt;
    assign val = val_reg;
    assign live = live_reg;
    assign hit = used && live_reg && (cmd.cmp || cmd.kill) && (val_reg == cmd.key);
    // a slot with a dead slot at or before it in use range
    assign hole = used && (!live_reg || left_hole);

    always_ff @(posedge clk)
    begin
        if (cmd.ins && idx > cmd.pos)
            val_reg <= left_val;
        else if (cmd.ins && idx == cmd.pos)
            val_reg <= cmd.key;
        else if (cmd.del && idx >= cmd.pos)
            val_reg <= right_val;
        else if (cmd.pack && hole)
            val_reg <= right_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            live_reg <= 1'b1;
        else if (cmd.kill && hit && idx > cmd.pos)
            live_reg <= 1'b0;
        else if (cmd.pack && hole)
            live_reg <= right_live;
        else if (cmd.ins || cmd.del)
            live_reg <= 1'b1;
    end
endmodule
`default_nettype wire

[hw/rtl/positional_array_list_engine_core.sv]
// insert, delete, search: after accept, an execute step into the cell row, then the
// max/min walk over the entries left after the item, then the result is valid
// duplicate removal: key passes over the slots in use, compaction steps that each remove
// one duplicate until no dead slot is left, then the max/min walk
// one item at a time: input stalled until the result is taken, next accept in the cycle after
// reset clears count and control and sets cell live bits; slot values need no reset
`default_nettype none
`include "positional_array_list_engine_core_assert.svh"
module positional_array_list_engine_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [6:0]  position,
    input  wire logic signed [31:0] value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [6:0]       found_position,
    output logic [6:0]       entry_count,
    output logic signed [31:0] max_value,
    output logic signed [31:0] min_value,
    output logic             list_empty
);
    localparam int D = pale_pkg::DEPTH;
    localparam int CW = pale_pkg::CW;
    localparam int IW = $clog2(D);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DKEY = 3'd2;   // dedup: mark duplicates of slot k
    localparam logic [2:0] S_PACK = 3'd3;   // dedup: compaction steps
    localparam logic [2:0] S_SCAN = 3'd4;   // max/min walk
    localparam logic [2:0] S_OUT = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    op_reg;
    logic [CW-1:0] pos_reg;          // 0-based
    logic [31:0]   key_reg;
    logic [CW-1:0] k_reg, k_next;    // dedup key slot / scan index
    logic [1:0]    st_reg;
    logic [1:0]    st_in;            // status decided at accept
    logic [6:0]    fnd_reg;
    logic signed [31:0] mx_reg, mn_reg;
    logic          pos_ok_ins, pos_ok_del;

    pale_pkg::pale_cmd_t cmd;
    logic [31:0] vals [D];
    logic [D-1:0] lives, hits, holes;

    // cell row; slot 0 is the list head
    for (genvar g = 0; g < D; g++)
    begin : g_cell
        pale_cell u_cell (
            .clk(clk), .rst_n(rst_n),
            .idx(CW'(g)), .cmd(cmd), .cnt(cnt_reg),
            .left_val(g == 0 ? 32'd0 : vals[(g == 0) ? 0 : g - 1]),
            .right_val(g == D - 1 ? 32'd0 : vals[(g == D - 1) ? g : g + 1]),
            .right_live(g == D - 1 ? 1'b1 : lives[(g == D - 1) ? g : g + 1]),
            .left_hole(g == 0 ? 1'b0 : holes[(g == 0) ? g : g - 1]),
            .val(vals[g]), .live(lives[g]), .hit(hits[g]), .hole(holes[g])
        );
    end

    // first match by priority over the row
    logic          any_hit;
    logic [IW-1:0] hit_idx;
    always_comb
    begin
        any_hit = 1'b0;
        hit_idx = '0;
        for (int i = D - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                any_hit = 1'b1;
                hit_idx = IW'(i);
            end
        end
    end

    assign pos_ok_ins = position != 7'd0 && ({1'b0, position} <= 8'(cnt_reg) + 8'd1);
    assign pos_ok_del = position != 7'd0 && ({1'b0, position} <= 8'(cnt_reg));

    // position is checked before the full list
    always_comb
    begin
        st_in = pale_pkg::ST_OK;
        unique case (op)
            pale_pkg::OP_INS:
                if (!pos_ok_ins)
                    st_in = pale_pkg::ST_BADPOS;
                else if (cnt_reg >= CW'(D))
                    st_in = pale_pkg::ST_FULL;
            pale_pkg::OP_DEL:
                if (!pos_ok_del)
                    st_in = pale_pkg::ST_BADPOS;
            default: ;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.pos = pos_reg;
        cmd.key = key_reg;
        if (state_reg == S_EXEC)
        begin
            cmd.ins = op_reg == pale_pkg::OP_INS && st_reg == pale_pkg::ST_OK;
            cmd.del = op_reg == pale_pkg::OP_DEL && st_reg == pale_pkg::ST_OK;
            cmd.cmp = op_reg == pale_pkg::OP_SRCH;
            cmd.key = key_reg;
        end
        else if (state_reg == S_DKEY)
        begin
            cmd.kill = 1'b1;
            cmd.pos = k_reg;
            cmd.key = vals[k_reg[IW-1:0]];
        end
        else if (state_reg == S_PACK)
            cmd.pack = 1'b1;
    end

    logic busy;
    assign busy = state_reg != S_IDLE;
    assign in_stall = busy;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        k_next = k_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_EXEC;
            S_EXEC:
            begin
                k_next = '0;
                if (op_reg == pale_pkg::OP_INS && st_reg == pale_pkg::ST_OK)
                    cnt_next = cnt_reg + 1'b1;
                else if (op_reg == pale_pkg::OP_DEL && st_reg == pale_pkg::ST_OK)
                    cnt_next = cnt_reg - 1'b1;
                state_next = (op_reg == pale_pkg::OP_DEDUP) ? S_DKEY : S_SCAN;
            end
            S_DKEY:
                if (k_reg >= cnt_reg)
                    state_next = S_PACK;
                else
                    k_next = k_reg + 1'b1;
            // each step closes the first dead slot, one entry fewer
            S_PACK:
                if (holes == '0)
                begin
                    state_next = S_SCAN;
                    k_next = '0;
                end
                else
                    cnt_next = cnt_reg - 1'b1;
            S_SCAN:
                if (k_reg >= cnt_reg)
                    state_next = S_OUT;
                else
                    k_next = k_reg + 1'b1;
            S_OUT:
                if (!out_stall)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            k_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            k_reg <= k_next;
        end
    end

    // payload capture and result build
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg <= op;
            pos_reg <= CW'(position) - 1'b1;
            key_reg <= value;
            fnd_reg <= '0;
            st_reg <= st_in;
        end
        if (state_reg == S_EXEC && op_reg == pale_pkg::OP_SRCH)
        begin
            st_reg <= any_hit ? pale_pkg::ST_OK : pale_pkg::ST_MISS;
            fnd_reg <= any_hit ? 7'(hit_idx) + 7'd1 : 7'd0;
        end
        if (state_reg == S_SCAN)
        begin
            if (k_reg < cnt_reg)
            begin
                if (k_reg == '0 || $signed(vals[k_reg[IW-1:0]]) > mx_reg)
                    mx_reg <= vals[k_reg[IW-1:0]];
                if (k_reg == '0 || $signed(vals[k_reg[IW-1:0]]) < mn_reg)
                    mn_reg <= vals[k_reg[IW-1:0]];
            end
            else if (k_reg == '0)
            begin
                // empty list reports zero extremes
                mx_reg <= '0;
                mn_reg <= '0;
            end
        end
    end

    assign out_valid = state_reg == S_OUT;
    assign status = st_reg;
    assign found_position = fnd_reg;
    assign entry_count = 7'(cnt_reg);
    assign max_value = mx_reg;
    assign min_value = mn_reg;
    assign list_empty = cnt_reg == '0;

    `PALE_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg <= CW'(D))
    `PALE_ASSERT_IMP(a_stall_busy, out_valid, in_stall)
    `PALE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status))
endmodule
`default_nettype wire
